### rtl/pmma_pkg.sv
// Package for the paged memory-access unit: sizes, function and status
// codes, page-entry bit positions, controller states and control structs.
// No dependencies.
package pmma_pkg;

	// Byte RAM geometry: four byte-wide banks, one row per aligned word
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W    = 16;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int BANKS     = 4;
	localparam int ROWS      = MEM_BYTES / BANKS;
	localparam int ROW_W     = MEM_AW - 2;

	// Payload widths
	localparam int FUNC_W    = 2;
	localparam int DATA_W    = 16;
	localparam int RDATA_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	// Page-table addressing
	localparam int PT_IDX_W  = 4;
	localparam int OFFSET_W  = 12;
	localparam int PTE_CLR_W = 5;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE16 = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE8  = 2'd2;

	// Status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_READ_OK   = 3'd0;
	localparam status_t ST_READ_ERR  = 3'd1;
	localparam status_t ST_WRITE_OK  = 3'd2;
	localparam status_t ST_WRITE_ERR = 3'd3;
	localparam status_t ST_DENIED    = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VIRT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;

	// Page entry flag positions
	localparam int PTE_PRESENT = 0;
	localparam int PTE_READ    = 1;
	localparam int PTE_WRITE   = 2;
	localparam int PTE_SUP     = 3;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PTE,
		S_ACCESS,
		S_RESP
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic pte_rd;
		logic access;
		logic load_out;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic virt_on;
	} dp_sts_t;

	// True when a byte address lies inside the RAM
	function automatic logic in_mem(input logic [ADDR_W-1:0] a);
		return {1'b0, a} < (ADDR_W + 1)'(MEM_BYTES);
	endfunction

endpackage

### rtl/pmma_if.sv
// Channel interfaces of the paged memory-access unit: request, response
// and configuration write. Depends on pmma_pkg.
interface pmma_req_if;
	logic                            valid;
	logic                            ready;
	logic [pmma_pkg::FUNC_W-1:0]     func;
	logic [pmma_pkg::ADDR_W-1:0]     vaddr;
	logic [pmma_pkg::DATA_W-1:0]     wdata;
	logic                            supervisor;

	modport source(output valid, func, vaddr, wdata, supervisor, input ready);
	modport sink(input valid, func, vaddr, wdata, supervisor, output ready);
endinterface

interface pmma_rsp_if;
	logic                            valid;
	logic                            ready;
	pmma_pkg::status_t               status;
	logic [pmma_pkg::RDATA_W-1:0]    rdata;

	modport source(output valid, status, rdata, input ready);
	modport sink(input valid, status, rdata, output ready);
endinterface

interface pmma_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pmma_pkg::CFG_IDX_W-1:0]  addr;
	logic [pmma_pkg::DATA_W-1:0]     data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

### rtl/pmma_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pmma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/pmma_ctrl.sv
// Controller of the paged memory-access unit: state machine sequencing
// clear pass, entry read, data access and result hand-off. Depends on pmma_pkg.
module pmma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pmma_pkg::dp_sts_t   sts,
	output pmma_pkg::ctrl_cmd_t cmd
);

	pmma_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmma_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmma_pkg::S_CLEAR: begin
				if (sts.clear_done) state_d = pmma_pkg::S_IDLE;
			end
			pmma_pkg::S_IDLE: begin
				if (in_valid) state_d = sts.virt_on ? pmma_pkg::S_PTE : pmma_pkg::S_ACCESS;
			end
			pmma_pkg::S_PTE: begin
				state_d = pmma_pkg::S_ACCESS;
			end
			pmma_pkg::S_ACCESS: begin
				state_d = pmma_pkg::S_RESP;
			end
			pmma_pkg::S_RESP: begin
				if (out_free) state_d = pmma_pkg::S_IDLE;
			end
			default: begin
				state_d = pmma_pkg::S_CLEAR;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pmma_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			pmma_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			pmma_pkg::S_PTE: begin
				cmd.pte_rd = 1'b1;
			end
			pmma_pkg::S_ACCESS: begin
				cmd.access = 1'b1;
			end
			pmma_pkg::S_RESP: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/pmma_dp.sv
// Datapath of the paged memory-access unit: configuration registers, item
// registers, translation and checks, banked byte RAM and result register.
// Depends on pmma_pkg and pmma_ram.
module pmma_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pmma_pkg::ctrl_cmd_t              cmd,
	output pmma_pkg::dp_sts_t                sts,
	input  logic                             cfg_valid,
	input  logic [pmma_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [pmma_pkg::DATA_W-1:0]      cfg_data,
	output logic                             cfg_ready,
	input  logic [pmma_pkg::FUNC_W-1:0]      in_func,
	input  logic [pmma_pkg::ADDR_W-1:0]      in_vaddr,
	input  logic [pmma_pkg::DATA_W-1:0]      in_wdata,
	input  logic                             in_supervisor,
	output pmma_pkg::status_t                out_status,
	output logic [pmma_pkg::RDATA_W-1:0]     out_rdata
);

	localparam int AW = pmma_pkg::ADDR_W;

	// Configuration
	logic                               virt_q;
	logic [AW-1:0]                      base_q;
	// Current item
	logic [pmma_pkg::FUNC_W-1:0]        func_q;
	logic [AW-1:0]                      vaddr_q;
	logic [pmma_pkg::DATA_W-1:0]        wdata_q;
	logic                               sup_q;
	// Clear pass
	logic [pmma_pkg::ROW_W-1:0]         clr_row_q;
	logic                               clr_done_q;
	// Access outcome
	pmma_pkg::status_t                  st_q;
	logic [1:0]                         pa_lo_q;
	// Result register
	pmma_pkg::status_t                  out_status_q;
	logic [pmma_pkg::RDATA_W-1:0]       out_rdata_q;

	// Bank ports
	logic [pmma_pkg::BANKS-1:0]         bank_en;
	logic [pmma_pkg::BANKS-1:0]         bank_we;
	logic [pmma_pkg::ROW_W-1:0]         bank_row [pmma_pkg::BANKS];
	logic [7:0]                         bank_wd  [pmma_pkg::BANKS];
	logic [7:0]                         bank_rd  [pmma_pkg::BANKS];

	// Translation
	logic [AW-1:0]                      pte_addr;
	logic [AW-1:0]                      pte_addr1;
	logic [7:0]                         pte_lo;
	logic [7:0]                         pte_hi;
	logic [15:0]                        entry;
	logic [AW-1:0]                      paddr;
	logic                               grant;
	logic                               may_rd;
	logic                               may_wr;
	logic                               rng_rd;
	logic                               rng_w16;
	logic                               rng_w8;
	logic                               do_write;
	pmma_pkg::status_t                  st_c;
	logic [AW-1:0]                      acc_addr;
	logic [pmma_pkg::RDATA_W-1:0]       rd_word;

	assign cfg_ready      = 1'b1;
	assign sts.clear_done = clr_done_q;
	assign sts.virt_on    = virt_q;
	assign out_status     = out_status_q;
	assign out_rdata      = out_rdata_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			virt_q <= 1'b0;
			base_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				pmma_pkg::CFG_VIRT: virt_q <= cfg_data[0];
				pmma_pkg::CFG_BASE: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture on an accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= in_func;
			vaddr_q <= in_vaddr;
			wdata_q <= in_wdata;
			sup_q   <= in_supervisor;
		end
	end

	// Clear-pass row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.clear && !clr_done_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == pmma_pkg::ROW_W'(pmma_pkg::ROWS - 1)) clr_done_q <= 1'b1;
		end
	end

	// Page entry address and assembly from the bank read registers
	assign pte_addr  = base_q + {{(AW - pmma_pkg::PT_IDX_W - 1){1'b0}},
		vaddr_q[AW-1 -: pmma_pkg::PT_IDX_W], 1'b0};
	assign pte_addr1 = pte_addr + AW'(1);
	assign pte_lo    = pmma_pkg::in_mem(pte_addr)  ? bank_rd[pte_addr[1:0]]  : 8'h00;
	assign pte_hi    = pmma_pkg::in_mem(pte_addr1) ? bank_rd[pte_addr1[1:0]] : 8'h00;
	assign entry     = {pte_hi, pte_lo};

	// Physical address and permissions
	always_comb begin
		grant = entry[pmma_pkg::PTE_PRESENT] && (sup_q || !entry[pmma_pkg::PTE_SUP]);
		if (virt_q) begin
			paddr  = {entry[15:pmma_pkg::PTE_CLR_W], {pmma_pkg::PTE_CLR_W{1'b0}}}
				+ {{(AW - pmma_pkg::OFFSET_W){1'b0}}, vaddr_q[pmma_pkg::OFFSET_W-1:0]};
			may_rd = grant && entry[pmma_pkg::PTE_READ];
			may_wr = grant && entry[pmma_pkg::PTE_WRITE];
		end else begin
			paddr  = vaddr_q;
			may_rd = 1'b1;
			may_wr = 1'b1;
		end
	end

	// Range checks and status
	assign rng_rd  = ({1'b0, paddr} + (AW + 1)'(3)) < (AW + 1)'(pmma_pkg::MEM_BYTES);
	assign rng_w16 = ({1'b0, paddr} + (AW + 1)'(2)) < (AW + 1)'(pmma_pkg::MEM_BYTES);
	assign rng_w8  = ({1'b0, paddr} + (AW + 1)'(1)) < (AW + 1)'(pmma_pkg::MEM_BYTES);

	always_comb begin
		do_write = 1'b0;
		case (func_q)
			pmma_pkg::FUNC_READ: begin
				if (!may_rd)     st_c = pmma_pkg::ST_DENIED;
				else if (rng_rd) st_c = pmma_pkg::ST_READ_OK;
				else             st_c = pmma_pkg::ST_READ_ERR;
			end
			pmma_pkg::FUNC_WRITE16: begin
				do_write = may_wr && rng_w16;
				if (!may_wr)      st_c = pmma_pkg::ST_DENIED;
				else if (rng_w16) st_c = pmma_pkg::ST_WRITE_OK;
				else              st_c = pmma_pkg::ST_WRITE_ERR;
			end
			pmma_pkg::FUNC_WRITE8: begin
				do_write = may_wr && rng_w8;
				if (!may_wr)     st_c = pmma_pkg::ST_DENIED;
				else if (rng_w8) st_c = pmma_pkg::ST_WRITE_OK;
				else             st_c = pmma_pkg::ST_WRITE_ERR;
			end
			default: begin
				st_c = pmma_pkg::ST_DENIED;
			end
		endcase
	end

	// Bank steering: byte k of an access at address a lives in bank (a + k) mod 4
	assign acc_addr = cmd.access ? paddr : pte_addr;

	always_comb begin
		logic [1:0]    k;
		logic [AW-1:0] ab;
		for (int b = 0; b < pmma_pkg::BANKS; b++) begin
			k  = 2'(b) - acc_addr[1:0];
			ab = acc_addr + {{(AW - 2){1'b0}}, k};
			bank_en[b]  = 1'b0;
			bank_we[b]  = 1'b0;
			bank_row[b] = ab[pmma_pkg::MEM_AW-1:2];
			bank_wd[b]  = (k == 2'd0) ? wdata_q[7:0] : wdata_q[15:8];
			if (cmd.clear) begin
				bank_en[b]  = !clr_done_q;
				bank_we[b]  = !clr_done_q;
				bank_row[b] = clr_row_q;
				bank_wd[b]  = 8'h00;
			end else if (cmd.pte_rd) begin
				bank_en[b] = (k < 2'd2);
			end else if (cmd.access) begin
				if (func_q == pmma_pkg::FUNC_READ) begin
					bank_en[b] = 1'b1;
				end else if (func_q == pmma_pkg::FUNC_WRITE16) begin
					bank_en[b] = do_write && (k < 2'd2);
					bank_we[b] = bank_en[b];
				end else begin
					bank_en[b] = do_write && (k == 2'd0);
					bank_we[b] = bank_en[b];
				end
			end
		end
	end

	// Byte banks
	for (genvar g = 0; g < pmma_pkg::BANKS; g++) begin : g_bank
		pmma_ram #(
			.WIDTH(8),
			.DEPTH(pmma_pkg::ROWS)
		) u_ram (
			.clk  (clk),
			.en   (bank_en[g]),
			.we   (bank_we[g]),
			.addr (bank_row[g]),
			.wdata(bank_wd[g]),
			.rdata(bank_rd[g])
		);
	end

	// Access outcome
	always_ff @(posedge clk) begin
		if (cmd.access) begin
			st_q    <= st_c;
			pa_lo_q <= paddr[1:0];
		end
	end

	// Little-endian word from the rotated bank outputs
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rd_word[8*k +: 8] = bank_rd[pa_lo_q + 2'(k)];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= st_q;
			out_rdata_q  <= (st_q == pmma_pkg::ST_READ_OK) ? rd_word : '0;
		end
	end

endmodule

### rtl/paged_mmu_memory_access.sv
// Paged memory-access unit with a single-level page table over a private
// byte RAM. Top level; depends on pmma_pkg, pmma_if, pmma_ctrl, pmma_dp.
//
// Channels: req takes one access transaction (func, vaddr, wdata,
// supervisor); rsp returns one transaction (status, rdata) per request;
// cfg writes virtual_enable (index 0) or table_base (index 1) and is
// always ready. Configuration is to be written only while no access is in
// flight; the unit does not enforce this. A request passes through the
// access and response states, preceded by a page-entry read state when
// translation is on; the next request is taken once it leaves the response
// state. Entry and data share the single port of each of the four byte
// banks, so the entry read and the data access follow one another.
// Results sit in an output register; the next request is accepted while a
// result waits, but its own result is held back until the register frees,
// so a stalled receiver stops the unit after one further request.
// Reset: the configuration and control registers clear and a clearing
// pass zeroes the RAM one row of four bytes a cycle, MEM_BYTES/4 = 16384
// rows, during which req is not ready. Configuration writes are taken
// during the pass.
module paged_mmu_memory_access (
	input  logic       clk,
	input  logic       arst_n,
	pmma_req_if.sink   req,
	pmma_rsp_if.source rsp,
	pmma_cfg_if.sink   cfg
);

	pmma_pkg::ctrl_cmd_t cmd;
	pmma_pkg::dp_sts_t   sts;

	// Sequencer
	pmma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Translation, RAM and result path
	pmma_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg.valid),
		.cfg_addr     (cfg.addr),
		.cfg_data     (cfg.data),
		.cfg_ready    (cfg.ready),
		.in_func      (req.func),
		.in_vaddr     (req.vaddr),
		.in_wdata     (req.wdata),
		.in_supervisor(req.supervisor),
		.out_status   (rsp.status),
		.out_rdata    (rsp.rdata)
	);

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the paged memory-access unit: directed table, then
// randomised phases under bursty requests and a patterned response stall.
// Depends on pmma_pkg, pmma_if and the paged_mmu_memory_access top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmma_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_CYCLES = 100000; // covers the RAM clearing pass after reset
	localparam int HOLD_AFTER      = 300;   // response count that triggers the long stall
	localparam int HOLD_CYCLES     = 400;
	localparam int TAIL_CYCLES     = 16;
	localparam int PHASE_ITEMS     = 205;
	localparam int N_PHASES        = 7;
	localparam int REPORT_MAX      = 10;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] vaddr;
		logic [DATA_W-1:0] wdata;
		logic              sup;
	} access_t;

	typedef struct packed {
		status_t             status;
		logic [RDATA_W-1:0]  rdata;
	} mmu_rsp_t;

	typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [FUNC_W-1:0]    func;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [ADDR_W-1:0]    vaddr;
		logic [DATA_W-1:0]    data;
		logic                 sup;
		logic                 typed;
		status_t              st;
		logic [RDATA_W-1:0]   rd;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	pmma_req_if req_ch();
	pmma_rsp_if rsp_ch();
	pmma_cfg_if cfg_ch();

	paged_mmu_memory_access u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the unit: byte RAM and both registers
	logic [7:0]        shadow_ram [MEM_BYTES] = '{default: 8'h00};
	logic              shadow_virt = 1'b0;
	logic [ADDR_W-1:0] shadow_base = '0;

	mmu_rsp_t          awaited_rsp [$];
	int                bad_count = 0;
	int                rsp_seen = 0;
	logic [ADDR_W-1:0] hot_vaddr [8];
	bit                req_up = 1'b0;
	bit                cfg_up = 1'b0;

	// Per-phase register settings; a negative base means a random one
	bit phase_virt       [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
	int phase_base       [N_PHASES] = '{'hFFFF, 'hFF00, 'h0000, 'hFFFF, -1, 'h0000, -1};
	bit phase_burst_only [N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

	// Directed rows. Page table at 0xFF00: page 0 RW, 1 read-only, 2 write-only,
	// 3 supervisor-only, 4 not present, 5 RW near the top of RAM (wraps), 15 empty.
	dir_row_t dir_rows [29] = '{
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h0000, 16'h0000, 1'b0, 1'b1, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'h0000, 16'hFFFF, 1'b1, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_READ_OK,
			32'h0000FFFF},
		'{ROW_ACCESS, FUNC_WRITE8,  CFG_VIRT, 16'hFFFE, 16'h5AA5, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE8,  CFG_VIRT, 16'hFFFF, 16'h1234, 1'b1, 1'b1, ST_WRITE_ERR, 32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFFFD, 16'hBEEF, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFFFE, 16'h0000, 1'b1, 1'b1, ST_WRITE_ERR, 32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'hFFFC, 16'h0000, 1'b0, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'hFFFD, 16'h0000, 1'b1, 1'b1, ST_READ_ERR,  32'h0},
		'{ROW_ACCESS, FUNC_UNUSED,  CFG_VIRT, 16'h1234, 16'h0000, 1'b1, 1'b1, ST_DENIED,    32'h0},
		'{ROW_CFG,    FUNC_READ,    CFG_BASE, 16'h0000, 16'hFF00, 1'b0, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF00, 16'h1007, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF02, 16'h2003, 1'b1, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF04, 16'h3005, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF06, 16'h400F, 1'b1, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF08, 16'h5006, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'hFF0A, 16'hFFE7, 1'b1, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'h1004, 16'hCAFE, 1'b0, 1'b1, ST_WRITE_OK,  32'h0},
		'{ROW_CFG,    FUNC_READ,    CFG_VIRT, 16'h0000, 16'h0001, 1'b0, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h0004, 16'h0000, 1'b0, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'h1010, 16'hABCD, 1'b1, 1'b1, ST_DENIED,    32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h2000, 16'h0000, 1'b1, 1'b1, ST_DENIED,    32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h3000, 16'h0000, 1'b0, 1'b1, ST_DENIED,    32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h3000, 16'h0000, 1'b1, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_WRITE16, CFG_VIRT, 16'h4000, 16'h7777, 1'b1, 1'b1, ST_DENIED,    32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h5FFC, 16'h0000, 1'b1, 1'b0, ST_READ_OK,   32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'h501F, 16'h0000, 1'b0, 1'b1, ST_READ_ERR,  32'h0},
		'{ROW_ACCESS, FUNC_WRITE8,  CFG_VIRT, 16'h501F, 16'h00C3, 1'b1, 1'b1, ST_WRITE_ERR, 32'h0},
		'{ROW_ACCESS, FUNC_READ,    CFG_VIRT, 16'hF000, 16'h0000, 1'b1, 1'b1, ST_DENIED,    32'h0}
	};

	// Translate, check permissions and perform the access on the shadow RAM
	function automatic mmu_rsp_t predict_access(input access_t a);
		mmu_rsp_t          r;
		logic [ADDR_W-1:0] ea, ea_next, pa;
		logic [15:0]       pte;
		logic              rd_ok, wr_ok;
		int                p;
		r.status = ST_DENIED;
		r.rdata  = '0;
		pa       = a.vaddr;
		rd_ok    = 1'b1;
		wr_ok    = 1'b1;
		if (shadow_virt) begin
			ea      = shadow_base + {11'd0, a.vaddr[15:12], 1'b0};
			ea_next = ea + 16'd1;
			pte     = {shadow_ram[ea_next], shadow_ram[ea]};
			pa      = {pte[15:5], 5'd0} + {4'd0, a.vaddr[11:0]};
			if (!pte[PTE_PRESENT] || (!a.sup && pte[PTE_SUP])) begin
				rd_ok = 1'b0;
				wr_ok = 1'b0;
			end else begin
				rd_ok = pte[PTE_READ];
				wr_ok = pte[PTE_WRITE];
			end
		end
		p = int'(pa);
		case (a.func)
			FUNC_READ: begin
				if (!rd_ok)
					r.status = ST_DENIED;
				else if (p + 3 < MEM_BYTES) begin
					r.status = ST_READ_OK;
					r.rdata  = {shadow_ram[p+3], shadow_ram[p+2], shadow_ram[p+1], shadow_ram[p]};
				end else
					r.status = ST_READ_ERR;
			end
			FUNC_WRITE16: begin
				if (!wr_ok)
					r.status = ST_DENIED;
				else if (p + 2 < MEM_BYTES) begin
					shadow_ram[p]   = a.wdata[7:0];
					shadow_ram[p+1] = a.wdata[15:8];
					r.status        = ST_WRITE_OK;
				end else
					r.status = ST_WRITE_ERR;
			end
			FUNC_WRITE8: begin
				if (!wr_ok)
					r.status = ST_DENIED;
				else if (p + 1 < MEM_BYTES) begin
					shadow_ram[p] = a.wdata[7:0];
					r.status      = ST_WRITE_OK;
				end else
					r.status = ST_WRITE_ERR;
			end
			default: r.status = ST_DENIED;
		endcase
		return r;
	endfunction

	// Random page entry: mostly present and read/write, sometimes arbitrary flags
	function automatic logic [15:0] random_pte();
		logic [3:0] flags;
		if ($urandom_range(0, 9) < 7)
			flags = {1'($urandom), 3'b111};
		else
			flags = 4'($urandom);
		return {11'($urandom), 1'($urandom), flags};
	endfunction

	// Random access aimed mostly at a few hot addresses and at range edges
	function automatic access_t random_access();
		access_t a;
		int      sel;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			a.func = FUNC_UNUSED;
		else if (sel < 45)
			a.func = FUNC_READ;
		else if (sel < 75)
			a.func = FUNC_WRITE16;
		else
			a.func = FUNC_WRITE8;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			a.vaddr = hot_vaddr[$urandom_range(0, 7)] + 16'($urandom_range(0, 3));
		else if (sel < 75)
			a.vaddr = {4'($urandom_range(0, 15)), 12'hFFC + 12'($urandom_range(0, 3))};
		else if (sel < 85)
			a.vaddr = 16'hFFF0 | 16'($urandom_range(0, 15));
		else
			a.vaddr = 16'($urandom);
		a.wdata = 16'($urandom);
		a.sup   = 1'($urandom);
		return a;
	endfunction

	task automatic req_lower();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	task automatic cfg_lower();
		if (cfg_up) begin
			cfg_ch.valid <= 1'b0;
			cfg_up = 1'b0;
		end
	endtask

	task automatic wait_drained();
		req_lower();
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	// One request transaction; valid stays up for a following item
	task automatic issue_access(input access_t a, input logic typed, input status_t t_st,
			input logic [RDATA_W-1:0] t_rd);
		mmu_rsp_t want;
		cfg_lower();
		req_ch.valid      <= 1'b1;
		req_ch.func       <= a.func;
		req_ch.vaddr      <= a.vaddr;
		req_ch.wdata      <= a.wdata;
		req_ch.supervisor <= a.sup;
		req_up = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		want = predict_access(a);
		if (typed) begin
			want.status = t_st;
			want.rdata  = t_rd;
		end
		awaited_rsp.push_back(want);
	endtask

	// Register write once idle; valid is lowered by the next request
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= val;
		cfg_up = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_VIRT)
			shadow_virt = val[0];
		else
			shadow_base = val;
	endtask

	task automatic set_mode(input logic virt, input logic [ADDR_W-1:0] base);
		cfg_write(CFG_VIRT, {15'd0, virt});
		cfg_write(CFG_BASE, base);
	endtask

	// Response check against the oldest expectation
	always @(posedge clk) begin : rsp_check
		mmu_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_seen++;
			if (awaited_rsp.size() == 0) begin
				bad_count++;
				if (bad_count <= REPORT_MAX)
					$display("%0t: response with none expected: status %0d rdata %08h",
						$realtime, rsp_ch.status, rsp_ch.rdata);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp_ch.status !== want.status) begin
					bad_count++;
					if (bad_count <= REPORT_MAX)
						$display("%0t: status mismatch: expected %0d, got %0d",
							$realtime, want.status, rsp_ch.status);
				end
				if (rsp_ch.rdata !== want.rdata) begin
					bad_count++;
					if (bad_count <= REPORT_MAX)
						$display("%0t: rdata mismatch: expected %08h, got %08h",
							$realtime, want.rdata, rsp_ch.rdata);
				end
			end
		end
	end

	// Receiver pacing: ready follows a random 16-bit pattern, redrawn as the step counter advances, with one long hold-off
	initial begin : rsp_pacing
		logic [15:0] pace_bits;
		int          step;
		bit          held;
		pace_bits = '1;
		step      = 0;
		held      = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && rsp_seen >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (step % 64 == 0) begin
					case ($urandom_range(0, 3))
						0: pace_bits = '1;
						1: pace_bits = 16'($urandom);
						2: pace_bits = 16'($urandom | $urandom);
						default: pace_bits = 16'($urandom & $urandom);
					endcase
				end
				rsp_ch.ready <= pace_bits[step % 16];
				step++;
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transaction for %0d cycles", quiet);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int                ph, n, burst, gap, k;
		logic [ADDR_W-1:0] base;
		access_t           acc;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.func       <= FUNC_READ;
		req_ch.vaddr      <= '0;
		req_ch.wdata      <= '0;
		req_ch.supervisor <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.addr       <= CFG_VIRT;
		cfg_ch.data       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				cfg_write(dir_rows[i].reg_idx, dir_rows[i].data);
			else begin
				acc.func  = dir_rows[i].func;
				acc.vaddr = dir_rows[i].vaddr;
				acc.wdata = dir_rows[i].data;
				acc.sup   = dir_rows[i].sup;
				issue_access(acc, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].rd);
			end
		end

		// Random phases; each virtual one first lays down a fresh page table
		for (ph = 0; ph < N_PHASES; ph++) begin
			base = (phase_base[ph] < 0) ? 16'($urandom) : 16'(phase_base[ph]);
			for (k = 0; k < 8; k++)
				hot_vaddr[k] = 16'($urandom);
			set_mode(1'b0, base);
			if (phase_virt[ph]) begin
				for (k = 0; k < 16; k++) begin
					acc.func  = FUNC_WRITE16;
					acc.vaddr = base + 16'(2 * k);
					acc.wdata = random_pte();
					acc.sup   = 1'($urandom);
					issue_access(acc, 1'b0, ST_READ_OK, '0);
				end
				set_mode(1'b1, base);
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 16);
				for (k = 0; k < burst && n < PHASE_ITEMS; k++) begin
					issue_access(random_access(), 1'b0, ST_READ_OK, '0);
					n++;
					// sender pause until every result is back
					if (n == PHASE_ITEMS / 2)
						wait_drained();
				end
				if (phase_burst_only[ph] || $urandom_range(0, 3) == 0)
					gap = 0;
				else
					gap = $urandom_range(1, 12);
				if (gap > 0) begin
					req_lower();
					repeat (gap) @(posedge clk);
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
